@@ rtl/shea_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed heading error angle: shared definitions
// Widths, angle constants and the CORDIC arctangent table in degrees, Q16.
// ----------------------------------------------------------------------------
package shea_pkg;

  localparam int COORD_WIDTH_DEF   = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int GUARD_BITS = 24;
  localparam int GROW_BITS  = 3;
  localparam int TABLE_LEN  = 24;

  localparam int HEADING_W = 18;
  localparam int ANGLE_W   = 17;
  localparam int ZW        = 26;
  localparam int ZQ_W      = ZW - 8;
  localparam int DIFF_W    = 20;
  localparam int TURN_W    = 18;

  localparam int DEG90_Q16    = 5898240;
  localparam int ROUND_HALF   = 128;
  localparam int FULL_TURN_Q8 = 92160;
  localparam int HALF_TURN_Q8 = 46080;

  localparam logic signed [ZW-1:0] ATAN_Q16 [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

endpackage

@@ rtl/shea_prerot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input stage
// Scales the target by the guard bits, turns a left-half vector by ninety
// degrees into the right half and flags a target at the origin.
// ----------------------------------------------------------------------------
module shea_prerot #(
  parameter int COORD_WIDTH = shea_pkg::COORD_WIDTH_DEF,
  parameter int XW          = COORD_WIDTH + shea_pkg::GUARD_BITS + shea_pkg::GROW_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]         target_x_i,
  input  logic signed [COORD_WIDTH-1:0]         target_y_i,
  input  logic signed [shea_pkg::HEADING_W-1:0] heading_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [XW-1:0]                  x_o,
  output logic signed [XW-1:0]                  y_o,
  output logic signed [shea_pkg::ZW-1:0]        z_o,
  output logic signed [shea_pkg::HEADING_W-1:0] heading_o,
  output logic                                  degenerate_o
);

  logic                                  valid_q;
  logic signed [XW-1:0]                  x_ext;
  logic signed [XW-1:0]                  y_ext;
  logic signed [XW-1:0]                  x_d, x_q;
  logic signed [XW-1:0]                  y_d, y_q;
  logic signed [shea_pkg::ZW-1:0]        z_d, z_q;
  logic signed [shea_pkg::HEADING_W-1:0] hd_q;
  logic                                  deg_d, deg_q;

  assign in_stall_o = valid_q & out_stall_i;

  assign x_ext = {{shea_pkg::GROW_BITS{target_x_i[COORD_WIDTH-1]}}, target_x_i,
                  {shea_pkg::GUARD_BITS{1'b0}}};
  assign y_ext = {{shea_pkg::GROW_BITS{target_y_i[COORD_WIDTH-1]}}, target_y_i,
                  {shea_pkg::GUARD_BITS{1'b0}}};

  always_comb begin
    x_d   = x_ext;
    y_d   = y_ext;
    z_d   = '0;
    deg_d = (target_x_i == '0) && (target_y_i == '0);
    if (x_ext[XW-1]) begin
      if (!y_ext[XW-1]) begin
        x_d = y_ext;
        y_d = -x_ext;
        z_d = shea_pkg::ZW'(shea_pkg::DEG90_Q16);
      end else begin
        x_d = -y_ext;
        y_d = x_ext;
        z_d = -shea_pkg::ZW'(shea_pkg::DEG90_Q16);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      hd_q  <= heading_i;
      deg_q <= deg_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign x_o          = x_q;
  assign y_o          = y_q;
  assign z_o          = z_q;
  assign heading_o    = hd_q;
  assign degenerate_o = deg_q;

endmodule

@@ rtl/shea_cordic_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC vectoring stage
// One micro-rotation toward the x axis with a fixed shift, registered.
// ----------------------------------------------------------------------------
module shea_cordic_stage #(
  parameter int XW    = shea_pkg::COORD_WIDTH_DEF + shea_pkg::GUARD_BITS + shea_pkg::GROW_BITS,
  parameter int STAGE = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [XW-1:0]                  x_i,
  input  logic signed [XW-1:0]                  y_i,
  input  logic signed [shea_pkg::ZW-1:0]        z_i,
  input  logic signed [shea_pkg::HEADING_W-1:0] heading_i,
  input  logic                                  degenerate_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [XW-1:0]                  x_o,
  output logic signed [XW-1:0]                  y_o,
  output logic signed [shea_pkg::ZW-1:0]        z_o,
  output logic signed [shea_pkg::HEADING_W-1:0] heading_o,
  output logic                                  degenerate_o
);

  logic                                  valid_q;
  logic signed [XW-1:0]                  xs;
  logic signed [XW-1:0]                  ys;
  logic                                  rot_pos;
  logic signed [XW-1:0]                  x_d, x_q;
  logic signed [XW-1:0]                  y_d, y_q;
  logic signed [shea_pkg::ZW-1:0]        z_d, z_q;
  logic signed [shea_pkg::HEADING_W-1:0] hd_q;
  logic                                  deg_q;

  assign in_stall_o = valid_q & out_stall_i;

  assign xs      = x_i >>> STAGE;
  assign ys      = y_i >>> STAGE;
  assign rot_pos = ~y_i[XW-1];

  always_comb begin
    if (rot_pos) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + shea_pkg::ATAN_Q16[STAGE];
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - shea_pkg::ATAN_Q16[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      hd_q  <= heading_i;
      deg_q <= degenerate_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign x_o          = x_q;
  assign y_o          = y_q;
  assign z_o          = z_q;
  assign heading_o    = hd_q;
  assign degenerate_o = deg_q;

endmodule

@@ rtl/shea_wrap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output stages
// Rounds the target direction to Q8, subtracts the heading, reduces the
// difference modulo a full turn and folds it into (-180, +180] degrees.
// ----------------------------------------------------------------------------
module shea_wrap (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [shea_pkg::ZW-1:0]        z_i,
  input  logic signed [shea_pkg::HEADING_W-1:0] heading_i,
  input  logic                                  degenerate_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [shea_pkg::ANGLE_W-1:0]   angle_o,
  output logic                                  degenerate_o
);

  localparam int DW = shea_pkg::DIFF_W;
  localparam int TW = shea_pkg::TURN_W;

  logic                                va_q, vb_q, vc_q;
  logic                                stall_a, stall_b, stall_c;
  logic signed [shea_pkg::ZW-1:0]      zsum;
  logic signed [shea_pkg::ZQ_W-1:0]    zq;
  logic signed [DW-1:0]                diff_d, diff_q;
  logic                                deg_a_q, deg_b_q, deg_c_q;
  logic signed [DW-1:0]                ext;
  logic signed [DW-1:0]                red;
  logic signed [TW-1:0]                turn_d, turn_q;
  logic signed [shea_pkg::ANGLE_W-1:0] angle_d, angle_q;

  assign stall_c    = vc_q & out_stall_i;
  assign stall_b    = vb_q & stall_c;
  assign stall_a    = va_q & stall_b;
  assign in_stall_o = stall_a;

  assign zsum   = z_i + shea_pkg::ZW'(shea_pkg::ROUND_HALF);
  assign zq     = zsum[shea_pkg::ZW-1:8];
  assign diff_d = DW'(zq) - DW'(heading_i);

  always_comb begin
    ext = diff_q + DW'(2 * shea_pkg::FULL_TURN_Q8);
    if (ext >= DW'(3 * shea_pkg::FULL_TURN_Q8)) begin
      red = ext - DW'(3 * shea_pkg::FULL_TURN_Q8);
    end else if (ext >= DW'(2 * shea_pkg::FULL_TURN_Q8)) begin
      red = ext - DW'(2 * shea_pkg::FULL_TURN_Q8);
    end else if (ext >= DW'(shea_pkg::FULL_TURN_Q8)) begin
      red = ext - DW'(shea_pkg::FULL_TURN_Q8);
    end else begin
      red = ext;
    end
    turn_d = red[TW-1:0];
  end

  always_comb begin
    if (deg_b_q) begin
      angle_d = '0;
    end else if (turn_q > TW'(shea_pkg::HALF_TURN_Q8)) begin
      angle_d = shea_pkg::ANGLE_W'(turn_q - TW'(shea_pkg::FULL_TURN_Q8));
    end else begin
      angle_d = shea_pkg::ANGLE_W'(turn_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (!stall_a) begin
        va_q <= in_valid_i;
      end
      if (!stall_b) begin
        vb_q <= va_q;
      end
      if (!stall_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !stall_a) begin
      diff_q  <= diff_d;
      deg_a_q <= degenerate_i;
    end
    if (va_q && !stall_b) begin
      turn_q  <= turn_d;
      deg_b_q <= deg_a_q;
    end
    if (vb_q && !stall_c) begin
      angle_q <= angle_d;
      deg_c_q <= deg_b_q;
    end
  end

  assign out_valid_o  = vc_q;
  assign angle_o      = angle_q;
  assign degenerate_o = deg_c_q;

endmodule

@@ rtl/signed_heading_error_angle.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed heading error angle
// Gives the signed angle in degrees (Q8) from the robot heading to a target
// offset, through a pipelined vectoring CORDIC.
//
// Usage: a transaction on the input channel (in_valid_i high, in_stall_o low)
// carries target_x_i, target_y_i and heading_i. Each input transaction gives
// exactly one output transaction carrying angle_o in (-180, +180] degrees and
// degenerate_o, which is set with a zero angle for a target at the origin.
// The result passes one input stage, one register per CORDIC micro-rotation
// and three stages for the rounding, heading subtraction and wrap.
// Throughput is one transaction per cycle while out_stall_i stays low, set
// by the unrolled rotation pipeline.
// Every stage has its own valid bit, so a stall on out_stall_i holds the
// result and the input keeps accepting until all stages behind it are full.
// Reset clears the valid bits only; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module signed_heading_error_angle #(
  parameter int COORD_WIDTH   = shea_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = shea_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]         target_x_i,
  input  logic signed [COORD_WIDTH-1:0]         target_y_i,
  input  logic signed [shea_pkg::HEADING_W-1:0] heading_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [shea_pkg::ANGLE_W-1:0]   angle_o,
  output logic                                  degenerate_o
);

  localparam int XW = COORD_WIDTH + shea_pkg::GUARD_BITS + shea_pkg::GROW_BITS;

  logic                                  valid_s [CORDIC_STAGES+1];
  logic                                  stall_s [CORDIC_STAGES+1];
  logic signed [XW-1:0]                  x_s     [CORDIC_STAGES+1];
  logic signed [XW-1:0]                  y_s     [CORDIC_STAGES+1];
  logic signed [shea_pkg::ZW-1:0]        z_s     [CORDIC_STAGES+1];
  logic signed [shea_pkg::HEADING_W-1:0] hd_s    [CORDIC_STAGES+1];
  logic                                  deg_s   [CORDIC_STAGES+1];

  shea_prerot #(
    .COORD_WIDTH (COORD_WIDTH),
    .XW          (XW)
  ) u_prerot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .target_x_i   (target_x_i),
    .target_y_i   (target_y_i),
    .heading_i    (heading_i),
    .out_valid_o  (valid_s[0]),
    .out_stall_i  (stall_s[0]),
    .x_o          (x_s[0]),
    .y_o          (y_s[0]),
    .z_o          (z_s[0]),
    .heading_o    (hd_s[0]),
    .degenerate_o (deg_s[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    shea_cordic_stage #(
      .XW    (XW),
      .STAGE (i)
    ) u_stage (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .in_valid_i   (valid_s[i]),
      .in_stall_o   (stall_s[i]),
      .x_i          (x_s[i]),
      .y_i          (y_s[i]),
      .z_i          (z_s[i]),
      .heading_i    (hd_s[i]),
      .degenerate_i (deg_s[i]),
      .out_valid_o  (valid_s[i+1]),
      .out_stall_i  (stall_s[i+1]),
      .x_o          (x_s[i+1]),
      .y_o          (y_s[i+1]),
      .z_o          (z_s[i+1]),
      .heading_o    (hd_s[i+1]),
      .degenerate_o (deg_s[i+1])
    );
  end

  shea_wrap u_wrap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_s[CORDIC_STAGES]),
    .in_stall_o   (stall_s[CORDIC_STAGES]),
    .z_i          (z_s[CORDIC_STAGES]),
    .heading_i    (hd_s[CORDIC_STAGES]),
    .degenerate_i (deg_s[CORDIC_STAGES]),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .angle_o      (angle_o),
    .degenerate_o (degenerate_o)
  );

  // A degenerate result always carries a zero angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (angle_o == '0))
    else $error("degenerate result with nonzero angle");

  // The angle always lies in the half-open range (-180, +180] degrees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((angle_o > -shea_pkg::ANGLE_W'(shea_pkg::HALF_TURN_Q8)) &&
                     (angle_o <= shea_pkg::ANGLE_W'(shea_pkg::HALF_TURN_Q8))))
    else $error("angle outside the half-turn range");

  // With no result waiting at the output, the pipeline cannot be full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output is empty");

endmodule

@@ verif/signed_heading_error_angle_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed heading error angle: self-checking testbench
// Sends target offsets and headings through the valid/stall input channel,
// computes the expected heading error angle with a bit-exact vectoring CORDIC
// written here, and compares every output transaction in order. Both sides
// idle at random, and the receiver three times holds off long enough to fill
// the pipeline and stall the input.
// ----------------------------------------------------------------------------
module signed_heading_error_angle_test;

  localparam int COORD_W     = shea_pkg::COORD_WIDTH_DEF;
  localparam int STAGES      = shea_pkg::CORDIC_STAGES_DEF;
  localparam int HEAD_W      = shea_pkg::HEADING_W;
  localparam int ANG_W       = shea_pkg::ANGLE_W;
  localparam int RANDOM_ITEMS = 1200;
  localparam int MAX_WAIT    = 12;
  localparam int HOLD_CYCLES = 120;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 40;
  localparam longint TURN    = 92160;
  localparam longint HALF    = 46080;
  localparam longint QUARTER = 5898240;
  localparam longint COORD_MAX = 8388607;
  localparam longint COORD_MIN = -8388608;

  localparam longint ATAN_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [HEAD_W-1:0]  hd;
  } target_t;

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    logic                    degenerate;
  } heading_err_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] target_x_i = '0;
  logic signed [COORD_W-1:0] target_y_i = '0;
  logic signed [HEAD_W-1:0]  heading_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b1;
  logic signed [ANG_W-1:0]   angle_o;
  logic                      degenerate_o;

  target_t      target_q[$];
  heading_err_t angle_q[$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  angles_seen = 0;
  int unsigned  idle_cycles = 0;
  logic         flood = 1'b0;

  signed_heading_error_angle dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .target_x_i   (target_x_i),
    .target_y_i   (target_y_i),
    .heading_i    (heading_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .angle_o      (angle_o),
    .degenerate_o (degenerate_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic heading_err_t heading_error(target_t t);
    longint x, y, z, xs, ys, zq, d, tmp;
    heading_err_t r;
    r.angle = '0;
    r.degenerate = 1'b0;
    if (t.x == 0 && t.y == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    x = longint'(t.x) * 64'sd16777216;
    y = longint'(t.y) * 64'sd16777216;
    z = 0;
    if (x < 0) begin
      tmp = x;
      if (y >= 0) begin
        x = y;
        y = -tmp;
        z = QUARTER;
      end else begin
        x = -y;
        y = tmp;
        z = -QUARTER;
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG[i];
      end
    end
    zq = (z + 128) >>> 8;
    d = (zq - longint'(t.hd)) % TURN;
    if (d < 0) d = d + TURN;
    if (d > HALF) d = d - TURN;
    r.angle = d[ANG_W-1:0];
    return r;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic longint spread(longint m);
    return longint'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic void add_target(longint x, longint y, longint h);
    target_t t;
    t.x = x[COORD_W-1:0];
    t.y = y[COORD_W-1:0];
    t.hd = h[HEAD_W-1:0];
    target_q.push_back(t);
  endfunction

  // Sender: offers queued targets, with a random pause after each transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned wait_left;
    int unsigned run_left;
    logic        offering;
    target_t     t;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      wait_left = 0;
      run_left = 0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        t.x = target_x_i;
        t.y = target_y_i;
        t.hd = heading_i;
        angle_q.push_back(heading_error(t));
        offering = 1'b0;
        wait_left = flood ? 0 : draw_wait(run_left);
      end
      if (!offering) begin
        if (wait_left > 0) begin
          wait_left--;
        end else if (target_q.size() != 0) begin
          t = target_q.pop_front();
          target_x_i <= t.x;
          target_y_i <= t.y;
          heading_i <= t.hd;
          offering = 1'b1;
        end
      end
      in_valid_i <= offering;
    end
  end

  // Receiver: checks each output transaction and draws its own stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned  stall_left;
    int unsigned  hold_left;
    int unsigned  run_left;
    logic         stall;
    heading_err_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      flood <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      run_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (angle_q.size() == 0) begin
          $error("output transaction with no target outstanding");
          mismatch_cnt++;
        end else begin
          want = angle_q.pop_front();
          if (angle_o !== want.angle) begin
            $error("angle: expected %0d, got %0d", want.angle, angle_o);
            mismatch_cnt++;
          end
          if (degenerate_o !== want.degenerate) begin
            $error("degenerate: expected %0d, got %0d", want.degenerate, degenerate_o);
            mismatch_cnt++;
          end
        end
        angles_seen++;
        if (angles_seen % 500 == 150) hold_left = HOLD_CYCLES;
        else stall_left = draw_wait(run_left);
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      out_stall_i <= stall;
      flood <= (hold_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    longint x, y, h;
    int unsigned pick;
    add_target(0, 0, 0);
    add_target(0, 0, 92160);
    add_target(256, 0, 0);
    add_target(-256, 0, 0);
    add_target(-256, 0, -46080);
    add_target(0, 256, 0);
    add_target(0, -256, 0);
    add_target(COORD_MAX, COORD_MAX, -92160);
    add_target(COORD_MIN, COORD_MIN, 92160);
    add_target(COORD_MIN, COORD_MAX, 0);
    add_target(COORD_MAX, COORD_MIN, 0);
    add_target(1, 0, 131071);
    add_target(0, -1, -131072);
    add_target(-1, -1, 0);
    add_target(COORD_MIN, 0, 46080);
    add_target(256, 256, 46080);
    add_target(-256, 0, -131072);
    add_target(COORD_MAX, 0, 46081);
    add_target(256, 1, 0);
    add_target(-256, -1, 0);
    add_target(COORD_MIN, 1, -46080);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      h = longint'($urandom_range(0, 184320)) - 92160;
      if (pick < 25) begin
        x = longint'(COORD_W'($urandom)) ;
        y = longint'(COORD_W'($urandom));
        h = longint'($urandom_range(0, 262143)) - 131072;
      end else if (pick < 45) begin
        x = spread(COORD_MAX);
        y = spread(COORD_MAX);
      end else if (pick < 65) begin
        x = spread(255);
        y = spread(255);
      end else if (pick < 75) begin
        x = spread(3);
        y = spread(3);
      end else if (pick < 87) begin
        x = ($urandom_range(0, 1) != 0) ? spread(COORD_MAX) : 0;
        y = (x == 0) ? spread(COORD_MAX) : 0;
      end else if (pick < 92) begin
        x = 0;
        y = 0;
      end else begin
        case ($urandom_range(0, 4))
          0: x = COORD_MIN;
          1: x = -1;
          2: x = 0;
          3: x = 1;
          default: x = COORD_MAX;
        endcase
        case ($urandom_range(0, 4))
          0: y = COORD_MIN;
          1: y = -1;
          2: y = 0;
          3: y = 1;
          default: y = COORD_MAX;
        endcase
      end
      add_target(x, y, h);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (target_q.size() != 0 || in_valid_i || angle_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/shea_pkg.sv
rtl/shea_prerot.sv
rtl/shea_cordic_stage.sv
rtl/shea_wrap.sv
rtl/signed_heading_error_angle.sv
verif/signed_heading_error_angle_test.sv
